// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CTRIM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CTRIM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ctrim_pkg.sv
`timescale 1ns / 1ps

package ctrim_pkg;

  localparam int unsigned TRIM_BITS = 3;
  localparam logic [TRIM_BITS-1:0] TRIM_MAX = {TRIM_BITS{1'b1}};
  localparam logic [TRIM_BITS-1:0] TRIM_ZERO = '0;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_SIGN     = 3'd1,
    PH_RESAMPLE = 3'd2,
    PH_UP       = 3'd3,
    PH_REF_HIGH = 3'd4,
    PH_DOWN     = 3'd5
  } phase_t;

  typedef struct packed {
    logic opcode;
    logic cmp_out;
  } in_item_t;

  typedef struct packed {
    logic [TRIM_BITS-1:0] trim_code;
    logic                 trim_positive;
    logic                 cal_enable;
    logic                 done_res;
  } out_item_t;

endpackage

// File: rtl/comparator_offset_trim_search_top.sv
`timescale 1ns / 1ps
// Comparator offset auto-trim sequencer.
// in_*  : one beat per command: opcode start (0) or settled comparator sample
//         (1) with cmp_out. A start restarts calibration at code 0; a sample
//         while idle is dropped and gives no beat.
// out_* : one beat per accepted command (except an idle sample) carrying the
//         trim code and sign to apply now, cal_enable, and done_res on the
//         final averaged code.
// cfg_* : one-bit write of resample_after_sign, always ready; write it only
//         while no command is in flight.
// A result beat is registered twice after its command is accepted: input
// register, then result register. One command per cycle while out_ready
// is not held low, set by the single state update between the two registers.
// A stalled out_ready holds the result register; the input register can still
// take one beat if empty, after which in_ready drops until out_ready returns.
// Reset (rst_n low, synchronous) empties both registers, returns to idle and
// clears the reference, sign, sweep and flip codes and the config bit.
`include "assert_macros.svh"

module comparator_offset_trim_search_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ctrim_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ctrim_pkg::out_item_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);

  logic                           resample_r;
  logic                           s1_valid_r;
  ctrim_pkg::in_item_t            s1_data_r;
  logic                           out_valid_r;
  ctrim_pkg::out_item_t           out_data_r;
  ctrim_pkg::phase_t              phase_r, phase_nxt;
  logic                           ref_r, ref_nxt;
  logic                           sign_r, sign_nxt;
  logic [ctrim_pkg::TRIM_BITS-1:0] sweep_r, sweep_nxt;
  logic [ctrim_pkg::TRIM_BITS-1:0] low_flip_r, low_flip_nxt;
  logic                           s1_adv;
  logic                           has_res;
  ctrim_pkg::out_item_t           res;
  logic                           diff;
  logic [ctrim_pkg::TRIM_BITS:0]  flip_sum;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign diff     = s1_data_r.cmp_out != ref_r;
  assign flip_sum = {1'b0, low_flip_r} + {1'b0, sweep_r};

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    ref_nxt      = ref_r;
    sign_nxt     = sign_r;
    sweep_nxt    = sweep_r;
    low_flip_nxt = low_flip_r;
    if (s1_data_r.opcode == ctrim_pkg::OP_START) begin
      phase_nxt    = ctrim_pkg::PH_SIGN;
      sweep_nxt    = ctrim_pkg::TRIM_ZERO;
      low_flip_nxt = ctrim_pkg::TRIM_ZERO;
    end else begin
      unique case (phase_r)
        ctrim_pkg::PH_SIGN: begin
          ref_nxt   = s1_data_r.cmp_out;
          sign_nxt  = !s1_data_r.cmp_out;
          sweep_nxt = ctrim_pkg::TRIM_ZERO;
          phase_nxt = resample_r ? ctrim_pkg::PH_RESAMPLE : ctrim_pkg::PH_UP;
        end
        ctrim_pkg::PH_RESAMPLE: begin
          ref_nxt   = s1_data_r.cmp_out;
          sweep_nxt = ctrim_pkg::TRIM_ZERO;
          phase_nxt = ctrim_pkg::PH_UP;
        end
        ctrim_pkg::PH_UP: begin
          if (diff || sweep_r == ctrim_pkg::TRIM_MAX) begin
            low_flip_nxt = diff ? sweep_r : ctrim_pkg::TRIM_ZERO;
            sweep_nxt    = ctrim_pkg::TRIM_MAX;
            phase_nxt    = ctrim_pkg::PH_REF_HIGH;
          end else begin
            sweep_nxt = sweep_r + 1'b1;
          end
        end
        ctrim_pkg::PH_REF_HIGH: begin
          ref_nxt   = s1_data_r.cmp_out;
          sweep_nxt = ctrim_pkg::TRIM_MAX;
          phase_nxt = ctrim_pkg::PH_DOWN;
        end
        ctrim_pkg::PH_DOWN: begin
          if (diff || sweep_r == ctrim_pkg::TRIM_ZERO) begin
            phase_nxt = ctrim_pkg::PH_IDLE;
          end else begin
            sweep_nxt = sweep_r - 1'b1;
          end
        end
        default: begin
          phase_nxt = ctrim_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // result
  always_comb begin
    has_res           = 1'b1;
    res.trim_code     = sweep_nxt;
    res.trim_positive = sign_nxt;
    res.cal_enable    = 1'b1;
    res.done_res      = 1'b0;
    if (s1_data_r.opcode == ctrim_pkg::OP_SAMPLE) begin
      unique case (phase_r)
        ctrim_pkg::PH_SIGN, ctrim_pkg::PH_RESAMPLE, ctrim_pkg::PH_UP,
        ctrim_pkg::PH_REF_HIGH: begin
          has_res = 1'b1;
        end
        ctrim_pkg::PH_DOWN: begin
          if (diff || sweep_r == ctrim_pkg::TRIM_ZERO) begin
            res.trim_code  = diff ? flip_sum[ctrim_pkg::TRIM_BITS:1] : low_flip_r;
            res.cal_enable = 1'b0;
            res.done_res   = 1'b1;
          end
        end
        default: begin
          has_res = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resample_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= ctrim_pkg::PH_IDLE;
      ref_r       <= 1'b0;
      sign_r      <= 1'b0;
      sweep_r     <= '0;
      low_flip_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        resample_r <= cfg_data;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      out_valid_r <= (out_valid_r && !out_ready) || (s1_adv && has_res);
      if (s1_adv) begin
        phase_r    <= phase_nxt;
        ref_r      <= ref_nxt;
        sign_r     <= sign_nxt;
        sweep_r    <= sweep_nxt;
        low_flip_r <= low_flip_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_adv && has_res) begin
      out_data_r <= res;
    end
  end

  `CTRIM_ASSERT_IMPL(a_done_ends_cal, out_valid_r && out_data_r.done_res,
    !out_data_r.cal_enable, "final code beat still has calibration enabled")

  `CTRIM_ASSERT_NEXT(a_done_to_idle, s1_adv && has_res && res.done_res,
    phase_r == ctrim_pkg::PH_IDLE, "sequencer not idle after final code")

  `CTRIM_ASSERT_NEXT(a_start_result, s1_adv && s1_data_r.opcode == ctrim_pkg::OP_START,
    out_valid_r && out_data_r.trim_code == ctrim_pkg::TRIM_ZERO && out_data_r.cal_enable,
    "start beat did not apply code zero in calibration mode")

  `CTRIM_ASSERT_NEXT(a_accept_loads, in_valid && in_ready,
    s1_valid_r, "accepted beat lost before the input register")

endmodule
